>>> hw/rtl/peer_table_with_aging_core_defines.svh
// ----------------------------------------------------------------------------
// Peer table assertion macros
// Concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PEER_TABLE_WITH_AGING_CORE_DEFINES_SVH
`define PEER_TABLE_WITH_AGING_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PTA_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication
`define PTA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`else

`define PTA_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define PTA_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/pta_pkg.sv
// ----------------------------------------------------------------------------
// Peer table package
// Shared widths, codes, entry layout and controller/datapath handshake types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pta_pkg;

   localparam int PEER_SLOTS_DEF = 16;

   localparam int ADDR_W     = 48;
   localparam int TIME_W     = 32;
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int SLOT_W     = 4;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIME_W-1:0] OFFLINE_RST = 32'd60000;
   localparam logic [TIME_W-1:0] REMOVE_RST  = 32'd300000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OFFLINE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REMOVE  = 1'b1;

   // item modes
   localparam logic [MODE_W-1:0] MODE_SEEN   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SWEEP  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_REFRESHED = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_ADDED     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_SWEPT     = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVAL,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [TIME_W-1:0] last_seen;
      logic              online;
   } entry_type;

   typedef struct packed {
      logic load;
      logic read;
      logic eval;
      logic close;
      logic update;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic is_seen;
      logic pass_done;
      logic rsp_free;
   } stat_type;

endpackage

>>> hw/rtl/pta_req_if.sv
// ----------------------------------------------------------------------------
// Peer table request channel
// Valid/ready channel carrying one table operation item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pta_req_if;
   logic                         valid;
   logic                         ready;
   logic [pta_pkg::MODE_W-1:0]   mode;
   logic [pta_pkg::ADDR_W-1:0]   peer_addr;
   logic [pta_pkg::TIME_W-1:0]   now_ms;

   modport source (output valid, mode, peer_addr, now_ms, input ready);
   modport sink   (input valid, mode, peer_addr, now_ms, output ready);
endinterface

>>> hw/rtl/pta_rsp_if.sv
// ----------------------------------------------------------------------------
// Peer table response channel
// Valid/ready channel carrying one result item per request item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pta_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pta_pkg::STATUS_W-1:0]  status;
   logic [pta_pkg::SLOT_W-1:0]    slot;
   logic [pta_pkg::COUNT_W-1:0]   peer_count;
   logic [pta_pkg::COUNT_W-1:0]   swept_offline;
   logic [pta_pkg::COUNT_W-1:0]   swept_removed;

   modport source (output valid, status, slot, peer_count, swept_offline, swept_removed,
                   input ready);
   modport sink   (input valid, status, slot, peer_count, swept_offline, swept_removed,
                   output ready);
endinterface

>>> hw/rtl/peer_table_with_aging_core.sv
// ----------------------------------------------------------------------------
// Peer table with aging
// Address-keyed peer table, packed in insertion order, with timed aging sweeps.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item: mode (seen, sweep, remove), a 48-bit peer
//   address and the current millisecond time. rsp_chan returns exactly one
//   result item per request item: status, slot, peer count and sweep counts.
//   The csr_ port writes the offline and remove age limits; write it only
//   while no item is in flight.
//   Each item walks the stored entries through a single-port entry memory
//   with registered read data, one entry at a time: read, then evaluate;
//   sweep, remove and unused items write the kept entries back in
//   compacted order, and a seen item then writes its entry in an update
//   step if it was found or the table has room. One item is worked on at
//   a time.
//   The result sits in an output register: a new item is accepted while the
//   previous result waits, and if the receiver still stalls when the next
//   result is ready, the block holds it and accepts nothing until it moves.
//   Reset (synchronous) empties the table and restores the default limits;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peer_table_with_aging_core #(
   parameter int PEER_SLOTS = pta_pkg::PEER_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [pta_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pta_pkg::CSR_DATA_W-1:0]  csr_wdata,
   pta_req_if.sink                         req_chan,
   pta_rsp_if.source                       rsp_chan
);

   pta_pkg::cmd_type  cmd;
   pta_pkg::stat_type stat;

   pta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pta_dpath #(
      .PEER_SLOTS (PEER_SLOTS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_mode          (req_chan.mode),
      .req_peer_addr     (req_chan.peer_addr),
      .req_now_ms        (req_chan.now_ms),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_status        (rsp_chan.status),
      .rsp_slot          (rsp_chan.slot),
      .rsp_peer_count    (rsp_chan.peer_count),
      .rsp_swept_offline (rsp_chan.swept_offline),
      .rsp_swept_removed (rsp_chan.swept_removed),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule

>>> hw/rtl/pta_ctrl.sv
// ----------------------------------------------------------------------------
// Peer table controller
// Sequences the scan/compaction pass for each item and the final update for seen items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pta_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pta_pkg::stat_type  stat,
   output pta_pkg::cmd_type   cmd
);

   pta_pkg::state_type state_ff;
   pta_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pta_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pta_pkg::ST_IDLE: begin
            if (req_valid) state_in = pta_pkg::ST_SCAN;
         end
         pta_pkg::ST_SCAN: begin
            if (!stat.pass_done) state_in = pta_pkg::ST_EVAL;
            else if (stat.is_seen) state_in = pta_pkg::ST_UPDATE;
            else state_in = pta_pkg::ST_FINISH;
         end
         pta_pkg::ST_EVAL: begin
            state_in = pta_pkg::ST_SCAN;
         end
         pta_pkg::ST_UPDATE: begin
            state_in = pta_pkg::ST_FINISH;
         end
         pta_pkg::ST_FINISH: begin
            if (stat.rsp_free) state_in = pta_pkg::ST_IDLE;
         end
         default: begin
            state_in = pta_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == pta_pkg::ST_IDLE);
      cmd         = '0;
      cmd.load    = (state_ff == pta_pkg::ST_IDLE) && req_valid;
      cmd.read    = (state_ff == pta_pkg::ST_SCAN) && !stat.pass_done;
      cmd.close   = (state_ff == pta_pkg::ST_SCAN) && stat.pass_done && !stat.is_seen;
      cmd.eval    = (state_ff == pta_pkg::ST_EVAL);
      cmd.update  = (state_ff == pta_pkg::ST_UPDATE);
      cmd.publish = (state_ff == pta_pkg::ST_FINISH) && stat.rsp_free;
   end

endmodule

>>> hw/rtl/pta_dpath.sv
// ----------------------------------------------------------------------------
// Peer table datapath
// Entry memory, limit registers, scan/compaction pointers and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "peer_table_with_aging_core_defines.svh"

module pta_dpath #(
   parameter int PEER_SLOTS = pta_pkg::PEER_SLOTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [pta_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pta_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [pta_pkg::MODE_W-1:0]       req_mode,
   input  logic [pta_pkg::ADDR_W-1:0]       req_peer_addr,
   input  logic [pta_pkg::TIME_W-1:0]       req_now_ms,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [pta_pkg::STATUS_W-1:0]     rsp_status,
   output logic [pta_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [pta_pkg::COUNT_W-1:0]      rsp_peer_count,
   output logic [pta_pkg::COUNT_W-1:0]      rsp_swept_offline,
   output logic [pta_pkg::COUNT_W-1:0]      rsp_swept_removed,
   input  pta_pkg::cmd_type                 cmd,
   output pta_pkg::stat_type                stat
);

   localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int CNT_W = $clog2(PEER_SLOTS + 1);
   localparam int EXT_W = CNT_W + pta_pkg::COUNT_W;

   // entry storage
   pta_pkg::entry_type mem [PEER_SLOTS];
   pta_pkg::entry_type rdata_ff;

   // limits
   logic [pta_pkg::TIME_W-1:0] cfg_offline_ff, cfg_offline_in;
   logic [pta_pkg::TIME_W-1:0] cfg_remove_ff, cfg_remove_in;

   // latched item
   logic [pta_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [pta_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [pta_pkg::TIME_W-1:0] now_ff, now_in;

   // pass state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] wr_ff, wr_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] hit_ff, hit_in;
   logic [CNT_W-1:0] n_off_ff, n_off_in;
   logic [CNT_W-1:0] n_rem_ff, n_rem_in;
   logic [pta_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IDX_W-1:0] res_slot_ff, res_slot_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pta_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [pta_pkg::SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [pta_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [pta_pkg::COUNT_W-1:0]   rsp_off_ff, rsp_off_in;
   logic [pta_pkg::COUNT_W-1:0]   rsp_rem_ff, rsp_rem_in;

   // evaluation of the entry just read
   logic [pta_pkg::TIME_W-1:0] age;
   logic                       is_old;
   logic                       is_stale;
   logic                       addr_hit;
   logic                       is_sweep;
   logic                       is_remove;
   logic                       is_seen;
   logic                       drop;
   logic                       has_room;
   pta_pkg::entry_type         kept;

   // write port
   logic                       we;
   logic [IDX_W-1:0]           waddr;
   pta_pkg::entry_type         wdata;

   logic [EXT_W-1:0] slot_ext;
   logic [EXT_W-1:0] count_ext;
   logic [EXT_W-1:0] off_ext;
   logic [EXT_W-1:0] rem_ext;

   assign is_seen   = (mode_ff == pta_pkg::MODE_SEEN);
   assign is_sweep  = (mode_ff == pta_pkg::MODE_SWEEP);
   assign is_remove = (mode_ff == pta_pkg::MODE_REMOVE);

   assign age      = now_ff - rdata_ff.last_seen;
   assign is_old   = (age > cfg_offline_ff);
   assign is_stale = is_old && (age > cfg_remove_ff);
   assign addr_hit = (rdata_ff.addr == addr_ff);
   // unused mode keeps every entry
   assign drop     = (is_sweep && is_stale) || (is_remove && addr_hit);
   assign has_room = (count_ff < CNT_W'(PEER_SLOTS));

   always_comb begin
      kept        = rdata_ff;
      kept.online = rdata_ff.online && !(is_sweep && is_old);
   end

   always_comb begin
      we    = 1'b0;
      waddr = wr_ff[IDX_W-1:0];
      wdata = kept;
      if (cmd.update) begin
         we              = found_ff || has_room;
         waddr           = found_ff ? hit_ff : count_ff[IDX_W-1:0];
         wdata.addr      = addr_ff;
         wdata.last_seen = now_ff;
         wdata.online    = 1'b1;
      end else if (cmd.eval) begin
         we = !is_seen && !drop;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.read) begin
         rdata_ff <= mem[rd_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      cfg_offline_in = cfg_offline_ff;
      cfg_remove_in  = cfg_remove_ff;
      if (csr_we) begin
         unique case (csr_index)
            pta_pkg::CSR_OFFLINE: cfg_offline_in = csr_wdata;
            pta_pkg::CSR_REMOVE:  cfg_remove_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      addr_in       = addr_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      found_in      = found_ff;
      hit_in        = hit_ff;
      n_off_in      = n_off_ff;
      n_rem_in      = n_rem_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;

      if (cmd.load) begin
         mode_in  = req_mode;
         addr_in  = req_peer_addr;
         now_in   = req_now_ms;
         rd_in    = '0;
         wr_in    = '0;
         found_in = 1'b0;
         hit_in   = '0;
         n_off_in = '0;
         n_rem_in = '0;
      end

      if (cmd.eval) begin
         rd_in = rd_ff + CNT_W'(1);
         if (!is_seen && !drop) begin
            wr_in = wr_ff + CNT_W'(1);
         end
         if ((is_seen || is_remove) && addr_hit && !found_ff) begin
            found_in = 1'b1;
            hit_in   = rd_ff[IDX_W-1:0];
         end
         if (is_sweep) begin
            n_off_in = n_off_ff + CNT_W'(is_old);
            n_rem_in = n_rem_ff + CNT_W'(is_stale);
         end
      end

      if (cmd.close) begin
         count_in    = wr_ff;
         res_slot_in = found_ff ? hit_ff : '0;
         if (is_sweep) res_status_in = pta_pkg::STAT_SWEPT;
         else if (is_remove && found_ff) res_status_in = pta_pkg::STAT_REMOVED;
         else res_status_in = pta_pkg::STAT_NOT_FOUND;
      end

      if (cmd.update) begin
         priority if (found_ff) begin
            res_status_in = pta_pkg::STAT_REFRESHED;
            res_slot_in   = hit_ff;
         end else if (has_room) begin
            res_status_in = pta_pkg::STAT_ADDED;
            res_slot_in   = count_ff[IDX_W-1:0];
            count_in      = count_ff + CNT_W'(1);
         end else begin
            res_status_in = pta_pkg::STAT_FULL;
            res_slot_in   = '0;
         end
      end
   end

   assign slot_ext  = EXT_W'(res_slot_ff);
   assign count_ext = EXT_W'(count_ff);
   assign off_ext   = EXT_W'(n_off_ff);
   assign rem_ext   = EXT_W'(n_rem_ff);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_rem_in    = rsp_rem_ff;
      if (cmd.publish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_slot_in   = slot_ext[pta_pkg::SLOT_W-1:0];
         rsp_count_in  = count_ext[pta_pkg::COUNT_W-1:0];
         rsp_off_in    = off_ext[pta_pkg::COUNT_W-1:0];
         rsp_rem_in    = rem_ext[pta_pkg::COUNT_W-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_offline_ff <= pta_pkg::OFFLINE_RST;
         cfg_remove_ff  <= pta_pkg::REMOVE_RST;
         count_ff       <= '0;
         rd_ff          <= '0;
         wr_ff          <= '0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cfg_offline_ff <= cfg_offline_in;
         cfg_remove_ff  <= cfg_remove_in;
         count_ff       <= count_in;
         rd_ff          <= rd_in;
         wr_ff          <= wr_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      addr_ff       <= addr_in;
      now_ff        <= now_in;
      hit_ff        <= hit_in;
      n_off_ff      <= n_off_in;
      n_rem_ff      <= n_rem_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_rem_ff    <= rsp_rem_in;
   end

   always_comb begin
      stat           = '0;
      stat.is_seen   = is_seen;
      stat.pass_done = (rd_ff == count_ff);
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_peer_count    = rsp_count_ff;
   assign rsp_swept_offline = rsp_off_ff;
   assign rsp_swept_removed = rsp_rem_ff;

   // compaction never writes past what it has read, and the table never overfills
   `PTA_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(PEER_SLOTS))
   `PTA_ASSERT_IMPLY(a_wr_behind_rd, clock, reset, 1'b1, wr_ff <= rd_ff)
   `PTA_ASSERT_NEXT(a_publish_valid, clock, reset, cmd.publish, rsp_valid_ff)

endmodule
